// ----- sv/semaphore_blocked_thread_table_unit_assert.svh -----
// Assertion macros for the semaphore blocked-thread table.
// Included by the top level; no other dependencies.
`ifndef SEMAPHORE_BLOCKED_THREAD_TABLE_UNIT_ASSERT_SVH
`define SEMAPHORE_BLOCKED_THREAD_TABLE_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SBT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define SBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- sv/sbtt_pkg.sv -----
// Package for the semaphore blocked-thread table: sizes, codes, hash.
// No dependencies.
`default_nettype none
package sbtt_pkg;
    localparam int NDESC = 32;
    localparam int NBKT = 16;
    localparam int NTHR = 64;
    localparam int DW = 6;   // descriptor link width, NDESC means none
    localparam int TW = 7;   // thread link width, NTHR means none
    localparam int BW = 4;
    localparam int IW = 6;   // thread id field width

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;
    localparam logic [1:0] OP_PULL   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [DW-1:0] NO_DESC = DW'(NDESC);
    localparam logic [TW-1:0] NO_THR  = TW'(NTHR);

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;       // capture request, read thread key
        logic key_pick;   // choose the key to hash, start hash
        logic hash_step;  // one mix round
        logic chain_init; // read bucket head
        logic chain_step; // advance chain walk
        logic q_init;     // start queue walk
        logic q_step;     // advance queue walk
        logic commit;     // apply update and register result
    } sbtt_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic hash_done;
        logic chain_done;
        logic q_done;
    } sbtt_stat_t;

    function automatic logic [31:0] mix_round(input logic [31:0] a, input logic [2:0] r);
        logic [31:0] b;
        b = a;
        case (r)
            3'd0: b = (a + 32'h7ed55d16) + (a << 12);
            3'd1: b = (a ^ 32'hc761c23c) ^ (a >> 19);
            3'd2: b = (a + 32'h165667b1) + (a << 5);
            3'd3: b = (a + 32'hd3a2646c) ^ (a << 9);
            3'd4: b = (a + 32'hfd7046c5) + (a << 3);
            3'd5: b = (a ^ 32'hb55a4f09) ^ (a >> 16);
            default: b = a;
        endcase
        return b;
    endfunction
endpackage
`default_nettype wire

// ----- sv/sbtt_ctrl.sv -----
// Controller for the semaphore blocked-thread table.
// Depends on sbtt_pkg.
`default_nettype none
module sbtt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output sbtt_pkg::sbtt_cmd_t    cmd,
    input  wire sbtt_pkg::sbtt_stat_t stat
);
    import sbtt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HASH  = 3'd1;
    localparam logic [2:0] S_CINIT = 3'd2;
    localparam logic [2:0] S_CHAIN = 3'd3;
    localparam logic [2:0] S_QINIT = 3'd4;
    localparam logic [2:0] S_QWALK = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;
    localparam logic [2:0] S_KEY   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    // Busy while a request is in flight; a waiting result only holds the commit.
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next = ov_reg && out_stall;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_KEY;
                end
            end
            S_KEY:
            begin
                cmd.key_pick = 1'b1;
                state_next = S_HASH;
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (stat.hash_done) state_next = S_CINIT;
            end
            S_CINIT:
            begin
                cmd.chain_init = 1'b1;
                state_next = S_CHAIN;
            end
            S_CHAIN:
            begin
                cmd.chain_step = 1'b1;
                if (stat.chain_done) state_next = S_QINIT;
            end
            S_QINIT:
            begin
                cmd.q_init = 1'b1;
                state_next = S_QWALK;
            end
            S_QWALK:
            begin
                cmd.q_step = 1'b1;
                if (stat.q_done) state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    cmd.commit = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end
endmodule
`default_nettype wire

// ----- sv/sbtt_dp.sv -----
// Datapath for the semaphore blocked-thread table: tables, hash, walks.
// Depends on sbtt_pkg.
`default_nettype none
module sbtt_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [1:0]           operation,
    input  wire logic [31:0]          sem_key,
    input  wire logic [5:0]           thread_id,
    input  wire sbtt_pkg::sbtt_cmd_t  cmd,
    output sbtt_pkg::sbtt_stat_t      stat,
    output logic [5:0]                result_thread,
    output logic [1:0]                status
);
    import sbtt_pkg::*;

    logic [DW-1:0] bucket_head_reg [NBKT];
    logic [31:0]   desc_key_mem    [NDESC];
    logic [DW-1:0] desc_next_reg   [NDESC];
    logic [TW-1:0] queue_head_mem  [NDESC];
    logic [TW-1:0] queue_tail_mem  [NDESC];
    logic [TW-1:0] thread_next_mem [NTHR];
    logic [31:0]   thread_key_mem  [NTHR];
    logic [NTHR-1:0] blocked_reg;
    logic [DW-1:0] free_head_reg;

    logic [1:0]    op_reg;
    logic [31:0]   key_reg;
    logic [IW-1:0] tid_reg;
    logic [31:0]   tkey_rd_reg;
    logic [31:0]   h_reg;
    logic [2:0]    round_reg;
    logic [DW-1:0] d_reg, p_reg;
    logic [6:0]    csteps_reg;
    logic [TW-1:0] t_reg, tp_reg;
    logic [TW-1:0] tn_reg;
    logic [7:0]    qsteps_reg;
    logic [5:0]    res_reg, res_next;
    logic [1:0]    st_reg, st_next;

    logic [BW-1:0] bkt;
    logic [DW-1:0] dn;
    logic          d_hit;
    logic          t_stop;
    logic          d_ok;
    logic [DW-2:0] di;
    logic [TW-1:0] qh;
    logic [TW-1:0] qt;
    logic [TW-1:0] tn_eff;
    logic [31:0]   pick_key;
    logic          ins_ok, ins_full, ins_do;
    logic          rem_do, rem_hit, rem_free;
    logic          peek_hit, pull_hit;

    assign bkt   = h_reg[BW-1:0];
    assign d_ok  = (d_reg < NO_DESC);
    assign di    = d_reg[DW-2:0];
    assign d_hit = d_ok && (desc_key_mem[di] == key_reg);
    assign dn    = d_ok ? desc_next_reg[di] : NO_DESC;
    assign qh    = queue_head_mem[di];
    assign qt    = queue_tail_mem[di];
    // The tail has no successor; its stored link is stale.
    assign tn_eff = (t_reg == qt) ? NO_THR : tn_reg;
    assign t_stop = (t_reg >= NO_THR) || (t_reg[IW-1:0] == tid_reg)
                    || (qsteps_reg > 8'(NTHR));
    // Pulls hash the thread's wait key; an unblocked thread has key zero.
    assign pick_key = (op_reg == OP_PULL) ? (blocked_reg[tid_reg] ? tkey_rd_reg : '0)
                                          : key_reg;

    assign stat.hash_done  = (round_reg == 3'd5);
    assign stat.chain_done = !d_ok || d_hit || (csteps_reg > 7'(NDESC));
    assign stat.q_done     = (op_reg != OP_PULL) || !d_ok || t_stop;

    assign result_thread = res_reg;
    assign status = st_reg;

    always_comb
    begin
        ins_ok   = (op_reg == OP_INSERT) && (key_reg != '0) && !blocked_reg[tid_reg];
        ins_full = ins_ok && !d_ok && (free_head_reg >= NO_DESC);
        ins_do   = ins_ok && !ins_full;
        rem_do   = (op_reg == OP_REMOVE) && (key_reg != '0) && d_ok;
        rem_hit  = rem_do && (qh < NO_THR);
        rem_free = rem_do && ((qh >= NO_THR) || (tn_eff >= NO_THR));
        peek_hit = (op_reg == OP_PEEK) && (key_reg != '0) && d_ok && (qh < NO_THR);
        pull_hit = (op_reg == OP_PULL) && (key_reg != '0) && d_ok && (t_reg < NO_THR)
                   && (t_reg[IW-1:0] == tid_reg);
    end

    always_comb
    begin
        res_next = '0;
        st_next = ST_NONE;
        if (ins_full)
            st_next = ST_FULL;
        else if (ins_do)
            st_next = ST_OK;
        else if (rem_hit || peek_hit)
        begin
            res_next = qh[IW-1:0];
            st_next = ST_OK;
        end
        else if (pull_hit)
        begin
            res_next = tid_reg;
            st_next = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= operation;
            tid_reg <= thread_id;
            key_reg <= sem_key;
            tkey_rd_reg <= thread_key_mem[thread_id];
        end
        if (cmd.key_pick)
        begin
            key_reg <= pick_key;
            h_reg <= pick_key;
            round_reg <= 3'd0;
        end
        if (cmd.hash_step)
        begin
            h_reg <= mix_round(h_reg, round_reg);
            round_reg <= round_reg + 3'd1;
        end
        if (cmd.chain_init)
        begin
            d_reg <= bucket_head_reg[bkt];
            p_reg <= NO_DESC;
            csteps_reg <= '0;
        end
        if (cmd.chain_step && !stat.chain_done)
        begin
            p_reg <= d_reg;
            d_reg <= dn;
            csteps_reg <= csteps_reg + 7'd1;
        end
        if (cmd.q_init)
        begin
            t_reg <= d_ok ? qh : NO_THR;
            tp_reg <= NO_THR;
            tn_reg <= thread_next_mem[qh[IW-1:0]];
            qsteps_reg <= '0;
        end
        if (cmd.q_step && !stat.q_done)
        begin
            tp_reg <= t_reg;
            t_reg <= tn_eff;
            tn_reg <= thread_next_mem[tn_eff[IW-1:0]];
            qsteps_reg <= qsteps_reg + 8'd1;
        end
    end

    // Commit: chains, free list and blocked flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NBKT; i++) bucket_head_reg[i] <= NO_DESC;
            for (int i = 0; i < NDESC; i++) desc_next_reg[i] <= DW'(i + 1);
            blocked_reg <= '0;
            free_head_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (ins_do)
            begin
                blocked_reg[tid_reg] <= 1'b1;
                if (!d_ok)
                begin
                    free_head_reg <= desc_next_reg[free_head_reg[DW-2:0]];
                    if (p_reg == NO_DESC) bucket_head_reg[bkt] <= free_head_reg;
                    else desc_next_reg[p_reg[DW-2:0]] <= free_head_reg;
                    desc_next_reg[free_head_reg[DW-2:0]] <= NO_DESC;
                end
            end
            if (rem_hit) blocked_reg[qh[IW-1:0]] <= 1'b0;
            if (rem_free)
            begin
                if (p_reg == NO_DESC) bucket_head_reg[bkt] <= dn;
                else desc_next_reg[p_reg[DW-2:0]] <= dn;
                desc_next_reg[di] <= free_head_reg;
                free_head_reg <= d_reg;
            end
            if (pull_hit) blocked_reg[tid_reg] <= 1'b0;
        end
    end

    // Queue and key memories and result register; no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_reg <= res_next;
            st_reg <= st_next;
            if (ins_do)
            begin
                thread_key_mem[tid_reg] <= key_reg;
                if (!d_ok)
                begin
                    desc_key_mem[free_head_reg[DW-2:0]] <= key_reg;
                    queue_head_mem[free_head_reg[DW-2:0]] <= TW'(tid_reg);
                    queue_tail_mem[free_head_reg[DW-2:0]] <= TW'(tid_reg);
                end
                else
                begin
                    if (qh >= NO_THR)
                        queue_head_mem[di] <= TW'(tid_reg);
                    else
                        thread_next_mem[qt[IW-1:0]] <= TW'(tid_reg);
                    queue_tail_mem[di] <= TW'(tid_reg);
                end
            end
            if (rem_hit)
            begin
                queue_head_mem[di] <= tn_eff;
                if (tn_eff >= NO_THR)
                    queue_tail_mem[di] <= NO_THR;
            end
            if (pull_hit)
            begin
                if (tp_reg >= NO_THR) queue_head_mem[di] <= tn_eff;
                else thread_next_mem[tp_reg[IW-1:0]] <= tn_eff;
                if (qt == t_reg)
                    queue_tail_mem[di] <= tp_reg;
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/semaphore_blocked_thread_table_unit.sv -----
// Top level of the semaphore blocked-thread table.
// Depends on sbtt_pkg, sbtt_ctrl, sbtt_dp and the assertion header.
//
// One request at a time: a beat on the input first reads the thread's wait
// key, is hashed (six mix rounds, one per cycle), then the bucket chain is
// walked one descriptor per cycle, then, for a pull, the wait queue is walked
// one thread per cycle. The next request is taken in the cycle after the
// commit. The result beat sits in an output register; a stalled result holds
// only the commit of the following request, not its acceptance. Per-thread
// blocked flags make unwritten wait keys read as zero, so there is no clearing
// pass after reset.
`default_nettype none
module semaphore_blocked_thread_table_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] sem_key,
    input  wire logic [5:0]  thread_id,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [5:0]       result_thread,
    output logic [1:0]       status
);
    import sbtt_pkg::*;

    sbtt_cmd_t  cmd;
    sbtt_stat_t stat;

    sbtt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
    );

    sbtt_dp u_dp (
        .clk(clk), .rst_n(rst_n), .operation(operation), .sem_key(sem_key),
        .thread_id(thread_id), .cmd(cmd), .stat(stat),
        .result_thread(result_thread), .status(status)
    );

`include "semaphore_blocked_thread_table_unit_assert.svh"
    `SBT_ASSERT_NEXT(a_hold_result, clk, rst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(result_thread), "stalled result changed")
    `SBT_ASSERT_IMPL(a_status_range, clk, rst_n, out_valid, status != 2'd3, "bad status code")
    `SBT_ASSERT_NEXT(a_commit_out, clk, rst_n, cmd.commit, out_valid, "commit without result")
endmodule
`default_nettype wire
